### rtl/core/gta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_pkg: shared types and constants for the GHASH tag accumulator
// Field widths, GF(2^128) reduction constant, digit geometry, state and
// register codes, and the byte padding mask.
// ----------------------------------------------------------------------------
package gta_pkg;

  localparam int BLOCK_BITS  = 128;
  localparam int HALF_BITS   = 64;
  localparam int BLOCK_BYTES = 16;
  localparam int COUNT_BITS  = 5;

  // Multiplier digit: bits of the multiplicand consumed per cycle
  localparam int DIGIT_BITS  = 8;
  localparam int DIGIT_COUNT = BLOCK_BITS / DIGIT_BITS;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_COUNT);

  // x^128 + x^7 + x^2 + x + 1 in the reflected bit order
  localparam logic [BLOCK_BITS-1:0] GF_REDUCE = {8'he1, 120'd0};

  typedef logic [BLOCK_BITS-1:0] block_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_DATA,
    ST_MUL_LEN,
    ST_EMIT
  } gta_state_t;

  typedef enum logic [1:0] {
    CFG_HASH_KEY_HI,
    CFG_HASH_KEY_LO,
    CFG_TAG_MASK_HI,
    CFG_TAG_MASK_LO
  } cfg_index_t;

  // Keep the leading cnt bytes of a block, clear the rest
  function automatic block_t gta_pad_mask(input logic [COUNT_BITS-1:0] cnt);
    block_t m;
    m = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (COUNT_BITS'(i) < cnt) begin
        m[BLOCK_BITS-1-8*i -: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

### rtl/core/ghash_tag_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghash_tag_accumulator_unit: GCM authentication tag over ciphertext
// Pads each ciphertext block, folds it into the GHASH accumulator through
// a digit-serial multiply by H, counts bytes, and on the last word absorbs
// the lengths block and emits accumulator XOR E(K,J0) as the tag.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       sink       in_valid / in_stall  block_hi, block_lo, byte_count, last
//  out      source     out_valid/out_stall  tag_hi, tag_lo
//  cfg      sink       cfg_we               cfg_index, cfg_wdata
//
//  A data word costs one GF(2^128) multiply on the 8-bit digit multiplier
//  plus a hand-off; a last word adds a second multiply for the lengths
//  block and a pass through ST_EMIT to load the tag. No new word is taken meanwhile.
//  A word with a byte count of zero and no last mark is taken and dropped.
//  Reset (synchronous, rst_n low) clears the accumulator, byte count,
//  configuration and output valid. A stalled tag stays in the output
//  register while the next message is already taken and hashed.
// ----------------------------------------------------------------------------
module ghash_tag_accumulator_unit #(
  parameter int LENGTH_BITS = 36
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  gta_pkg::cfg_index_t          cfg_index,
  input  logic [gta_pkg::HALF_BITS-1:0] cfg_wdata,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gta_pkg::HALF_BITS-1:0] in_block_hi,
  input  logic [gta_pkg::HALF_BITS-1:0] in_block_lo,
  input  logic [gta_pkg::COUNT_BITS-1:0] in_byte_count,
  input  logic                         in_last,
  // tag words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gta_pkg::HALF_BITS-1:0] out_tag_hi,
  output logic [gta_pkg::HALF_BITS-1:0] out_tag_lo
);
  import gta_pkg::*;

  // configuration registers
  logic [HALF_BITS-1:0] hkey_hi_r, hkey_lo_r;
  logic [HALF_BITS-1:0] tmask_hi_r, tmask_lo_r;

  // hashing state
  gta_state_t             state_r, state_nxt;
  block_t                 accum_r, accum_nxt;
  logic [LENGTH_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic                   last_r, last_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [HALF_BITS-1:0] out_tag_hi_r, out_tag_hi_nxt;
  logic [HALF_BITS-1:0] out_tag_lo_r, out_tag_lo_nxt;

  // multiplier hand-off
  logic   mul_start;
  block_t mul_x;
  logic   mul_busy;
  logic   mul_done;
  block_t mul_z;

  logic                  in_take;
  logic [COUNT_BITS-1:0] cnt_sat;
  block_t                padded;
  block_t                len_block;
  logic                  out_free;

  // Clamp the byte count to a whole block and clear the tail bytes
  assign cnt_sat   = (in_byte_count > COUNT_BITS'(BLOCK_BYTES)) ?
                     COUNT_BITS'(BLOCK_BYTES) : in_byte_count;
  assign padded    = {in_block_hi, in_block_lo} & gta_pad_mask(cnt_sat);
  // lengths block: AAD length zero, ciphertext length in bits
  assign len_block = {{HALF_BITS{1'b0}}, HALF_BITS'(bytes_seen_r) << 3};

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    accum_nxt      = accum_r;
    bytes_seen_nxt = bytes_seen_r;
    last_nxt       = last_r;
    mul_start      = 1'b0;
    mul_x          = accum_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_tag_hi_nxt = out_tag_hi_r;
    out_tag_lo_nxt = out_tag_lo_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          last_nxt = in_last;
          if (cnt_sat != '0) begin
            // absorb the data block, advance the byte count
            mul_x          = accum_r ^ padded;
            mul_start      = 1'b1;
            bytes_seen_nxt = bytes_seen_r + LENGTH_BITS'(cnt_sat);
            state_nxt      = ST_MUL_DATA;
          end else if (in_last) begin
            // empty word closing the message: lengths block only
            mul_x     = accum_r ^ len_block;
            mul_start = 1'b1;
            state_nxt = ST_MUL_LEN;
          end
        end
      end
      ST_MUL_DATA: begin
        if (mul_done) begin
          accum_nxt = mul_z;
          if (last_r) begin
            mul_x     = mul_z ^ len_block;
            mul_start = 1'b1;
            state_nxt = ST_MUL_LEN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MUL_LEN: begin
        if (mul_done) begin
          accum_nxt = mul_z;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the tag until the output register frees, then clear the message
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_tag_hi_nxt = accum_r[BLOCK_BITS-1 -: HALF_BITS] ^ tmask_hi_r;
          out_tag_lo_nxt = accum_r[HALF_BITS-1:0] ^ tmask_lo_r;
          accum_nxt      = '0;
          bytes_seen_nxt = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      accum_r      <= '0;
      bytes_seen_r <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      accum_r      <= accum_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_hi_r <= out_tag_hi_nxt;
    out_tag_lo_r <= out_tag_lo_nxt;
  end

  // Configuration writes land directly in their registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hkey_hi_r  <= '0;
      hkey_lo_r  <= '0;
      tmask_hi_r <= '0;
      tmask_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HASH_KEY_HI: hkey_hi_r  <= cfg_wdata;
        CFG_HASH_KEY_LO: hkey_lo_r  <= cfg_wdata;
        CFG_TAG_MASK_HI: tmask_hi_r <= cfg_wdata;
        CFG_TAG_MASK_LO: tmask_lo_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gta_gf_mul u_gf_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x_in  (mul_x),
    .h_in  ({hkey_hi_r, hkey_lo_r}),
    .busy  (mul_busy),
    .done  (mul_done),
    .z_out (mul_z)
  );

  assign out_valid  = out_valid_r;
  assign out_tag_hi = out_tag_hi_r;
  assign out_tag_lo = out_tag_lo_r;

`ifndef SYNTHESIS
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL_DATA || state_r == ST_MUL_LEN))
    else $error("multiplier result arrived outside a multiply state");
  a_busy_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_busy |-> (state_r == ST_MUL_DATA || state_r == ST_MUL_LEN))
    else $error("multiplier running while control is not waiting on it");
  a_tag_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) ##1 out_valid_r |-> $past(state_r == ST_EMIT))
    else $error("tag loaded without an emit");
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> (bytes_seen_r == '0 && accum_r == '0))
    else $error("message state not cleared after tag");
`endif

endmodule

### rtl/core/gta_gf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_gf_mul: digit-serial GF(2^128) multiplier
// Shifts the multiplicand out one digit per cycle, MSB first, folding the
// shifted key into the product; done pulses once the last digit is in.
// ----------------------------------------------------------------------------
module gta_gf_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  gta_pkg::block_t x_in,
  input  gta_pkg::block_t h_in,
  output logic           busy,
  output logic           done,
  output gta_pkg::block_t z_out
);
  import gta_pkg::*;

  block_t                 x_r, x_nxt;
  block_t                 v_r, v_nxt;
  block_t                 z_r, z_nxt;
  logic [DIGIT_IDX_W-1:0] cnt_r;
  logic                   busy_r;
  logic                   done_r;

  // One digit of shift-and-add with reduction
  always_comb begin
    block_t zt;
    block_t vt;
    zt = z_r;
    vt = v_r;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (x_r[BLOCK_BITS-1-j]) begin
        zt = zt ^ vt;
      end
      vt = vt[0] ? ((vt >> 1) ^ GF_REDUCE) : (vt >> 1);
    end
    z_nxt = zt;
    v_nxt = vt;
    x_nxt = x_r << DIGIT_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIGIT_IDX_W'(DIGIT_COUNT - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x_in;
      v_r <= h_in;
      z_r <= '0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      v_r <= v_nxt;
      z_r <= z_nxt;
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign z_out = z_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("done without a finished pass");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held for more than one cycle");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for ghash_tag_accumulator_unit
// Streams ciphertext words through the GHASH unit over several hash keys and
// tag masks. A local GF(2^128) model predicts the tag of every message, and
// each tag the unit emits is checked against the oldest prediction. Sender
// bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module testbench;

  import gta_pkg::*;

  localparam int TALLY_BITS   = 36;
  localparam int SETTLE_WAIT  = 64;       // cycles allowed after the last tag
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 800;

  // one input word as the sender holds it
  typedef struct {
    logic [HALF_BITS-1:0]  hi;
    logic [HALF_BITS-1:0]  lo;
    logic [COUNT_BITS-1:0] cnt;
    logic                  last;
  } ct_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_SOLID,
    STALL_SPARSE
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_HASH_KEY_HI;
  logic [HALF_BITS-1:0]  cfg_wdata = '0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [HALF_BITS-1:0]  in_block_hi = '0;
  logic [HALF_BITS-1:0]  in_block_lo = '0;
  logic [COUNT_BITS-1:0] in_byte_count = '0;
  logic                  in_last = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [HALF_BITS-1:0]  out_tag_hi;
  logic [HALF_BITS-1:0]  out_tag_lo;

  ghash_tag_accumulator_unit #(
    .LENGTH_BITS(TALLY_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_block_hi  (in_block_hi),
    .in_block_lo  (in_block_lo),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tag_hi   (out_tag_hi),
    .out_tag_lo   (out_tag_lo)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // GHASH model: shadow of the key registers and of the running state
  // --------------------------------------------------------------------------
  block_t                hash_key = '0;
  block_t                tag_mask = '0;
  block_t                ghash_acc = '0;
  logic [TALLY_BITS-1:0] byte_tally = '0;

  block_t                tag_expect[$];
  ct_word_t              word_backlog[$];
  int unsigned           words_queued = 0;
  int unsigned           words_taken = 0;
  int unsigned           fail_count = 0;

  // Multiply in GF(2^128), GCM bit order: the MSB of x is the x^0 term.
  function automatic block_t gf_mul(input block_t x, input block_t y);
    block_t z;
    block_t v;
    int     i;
    z = '0;
    v = y;
    for (i = BLOCK_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        z ^= v;
      end
      v = v[0] ? ((v >> 1) ^ GF_REDUCE) : (v >> 1);
    end
    return z;
  endfunction

  // Fold one accepted word into the model; queue a tag on the last word.
  task automatic ghash_absorb(input ct_word_t w);
    block_t      pad;
    int unsigned n;
    n = (w.cnt > BLOCK_BYTES) ? BLOCK_BYTES : w.cnt;
    if (n != 0) begin
      // keep the leading n bytes only
      pad = {BLOCK_BITS{1'b1}} << (8 * (BLOCK_BYTES - n));
      ghash_acc = gf_mul(ghash_acc ^ ({w.hi, w.lo} & pad), hash_key);
      byte_tally = byte_tally + TALLY_BITS'(n);
    end
    if (w.last) begin
      // lengths block: zero AAD length, ciphertext length in bits
      ghash_acc = gf_mul(ghash_acc ^ block_t'({byte_tally, 3'b000}), hash_key);
      tag_expect.push_back(ghash_acc ^ tag_mask);
      ghash_acc = '0;
      byte_tally = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of words from the backlog, random idle gaps between them
  // --------------------------------------------------------------------------
  ct_word_t    word_on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      // the word on the bus, if any, is taken at this edge
      if (in_valid) begin
        ghash_absorb(word_on_bus);
        words_taken++;
      end
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (word_backlog.size() != 0) begin
        word_on_bus = word_backlog.pop_front();
        in_block_hi   <= word_on_bus.hi;
        in_block_lo   <= word_on_bus.lo;
        in_byte_count <= word_on_bus.cnt;
        in_last       <= word_on_bus.last;
        in_valid      <= 1'b1;
        if (burst_left <= 1) begin
          // end of burst: pick the next burst length and the gap before it
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: segments of free flow, coin flips, solid and sparse stalls
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(4, 48);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
      STALL_SOLID:  out_stall <= 1'b1;
      default:      out_stall <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted tag against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tag_expect.size() == 0) begin
        $display("%0t: unexpected tag word, expected none, got %h_%h",
                 $time, out_tag_hi, out_tag_lo);
        fail_count++;
      end else begin
        want = tag_expect.pop_front();
        if (out_tag_hi !== want[BLOCK_BITS-1 -: HALF_BITS]) begin
          $display("%0t: tag_hi mismatch, expected %h, got %h",
                   $time, want[BLOCK_BITS-1 -: HALF_BITS], out_tag_hi);
          fail_count++;
        end
        if (out_tag_lo !== want[HALF_BITS-1:0]) begin
          $display("%0t: tag_lo mismatch, expected %h, got %h",
                   $time, want[HALF_BITS-1:0], out_tag_lo);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: give up on a hung run
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [HALF_BITS-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_word(input logic [HALF_BITS-1:0] hi, input logic [HALF_BITS-1:0] lo,
                           input int unsigned cnt, input logic last);
    ct_word_t w;
    w.hi   = hi;
    w.lo   = lo;
    w.cnt  = COUNT_BITS'(cnt);
    w.last = last;
    word_backlog.push_back(w);
    words_queued++;
  endtask

  // Program H and E(K,J0); only called while the unit is idle.
  task automatic program_keys(input block_t key, input block_t mask);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HASH_KEY_HI;
    cfg_wdata <= key[BLOCK_BITS-1 -: HALF_BITS];
    @(posedge clk);
    cfg_index <= CFG_HASH_KEY_LO;
    cfg_wdata <= key[HALF_BITS-1:0];
    @(posedge clk);
    cfg_index <= CFG_TAG_MASK_HI;
    cfg_wdata <= mask[BLOCK_BITS-1 -: HALF_BITS];
    @(posedge clk);
    cfg_index <= CFG_TAG_MASK_LO;
    cfg_wdata <= mask[HALF_BITS-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    hash_key = key;
    tag_mask = mask;
  endtask

  // Hold until every queued word is taken and every tag has come back,
  // then wait out the settle time before going on.
  task automatic drain_all();
    while (words_taken != words_queued || tag_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // One well-formed message with random content; returns the words that count.
  task automatic push_random_message(output int unsigned counted);
    int unsigned n;
    int unsigned k;
    int unsigned sel;
    int unsigned cnt;
    counted = 0;
    n = $urandom_range(0, 5);
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        cnt = 0;                          // dropped by the unit
      end else if (sel == 1) begin
        cnt = $urandom_range(1, 15);      // short word in mid-stream
      end else if (sel == 2) begin
        cnt = $urandom_range(17, 31);     // oversized count
      end else begin
        cnt = BLOCK_BYTES;
      end
      push_word(rand64(), rand64(), cnt, 1'b0);
      if (cnt != 0) begin
        counted++;
      end
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      cnt = 0;
    end else if (sel == 1) begin
      cnt = $urandom_range(17, 31);
    end else begin
      cnt = $urandom_range(1, BLOCK_BYTES);
    end
    push_word(rand64(), rand64(), cnt, 1'b1);
    counted++;
  endtask

  initial begin
    logic [HALF_BITS-1:0] ones;
    int unsigned          phase;
    int unsigned          phase_words;
    int unsigned          total_words;
    int unsigned          msg_words;
    block_t               key;
    block_t               mask;

    ones = '1;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: zero key and mask, so every tag must be zero
    push_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
    push_word(rand64(), rand64(), 7, 1'b1);
    drain_all();

    // Directed words under a random key
    program_keys({rand64(), rand64()}, {rand64(), rand64()});
    push_word('0, '0, 0, 1'b1);                         // empty message
    push_word(ones, ones, BLOCK_BYTES, 1'b1);           // all ones
    push_word('0, '0, BLOCK_BYTES, 1'b1);               // all zeros
    push_word(rand64(), rand64(), 1, 1'b1);
    push_word(rand64(), rand64(), 8, 1'b1);             // hi half only
    push_word(rand64(), rand64(), 9, 1'b1);             // crosses into lo half
    push_word(rand64(), rand64(), 15, 1'b1);
    push_word(ones, ones, 31, 1'b1);                    // count above sixteen
    push_word(rand64(), rand64(), 17, 1'b0);
    push_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
    push_word(rand64(), rand64(), 0, 1'b1);             // tag of what came before
    push_word(rand64(), rand64(), 0, 1'b0);             // dropped word
    push_word(rand64(), rand64(), 4, 1'b1);
    push_word(rand64(), rand64(), 5, 1'b0);             // short, not last
    push_word(rand64(), rand64(), BLOCK_BYTES, 1'b0);
    push_word(rand64(), rand64(), 3, 1'b1);
    push_word(ones, ones, BLOCK_BYTES, 1'b0);
    push_word(ones, ones, BLOCK_BYTES, 1'b1);
    drain_all();

    // Random messages across a spread of key settings, draining between them
    total_words = 0;
    phase = 0;
    while (total_words < RANDOM_WORDS) begin
      case (phase)
        0: begin
          key  = '1;
          mask = '1;
        end
        1: begin
          key  = {1'b1, {(BLOCK_BITS-1){1'b0}}};   // multiplicative identity
          mask = '0;
        end
        2: begin
          key  = '0;
          mask = {rand64(), rand64()};
        end
        default: begin
          key  = {rand64(), rand64()};
          mask = {rand64(), rand64()};
        end
      endcase
      program_keys(key, mask);
      phase_words = 0;
      while (phase_words < 130 && total_words + phase_words < RANDOM_WORDS) begin
        push_random_message(msg_words);
        phase_words += msg_words;
      end
      total_words += phase_words;
      drain_all();
      phase++;
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
